// ===== hw/rtl/pbsl_pkg.sv =====
// Package with shared types, constants and the band table lookup for the PLL serial loader.
package pbsl_pkg;

   localparam int unsigned FreqWidthDef  = 19;
   localparam int unsigned RefWidthDef   = 14;
   localparam int unsigned NWidthDef     = 10;
   localparam int unsigned AWidthDef     = 7;
   localparam int unsigned QueueDepthDef = 4;

   // Configuration port layout.
   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth  = 16;
   localparam int unsigned RefCountWidth = 14;
   localparam logic [RefCountWidth-1:0] RefCountReset = 14'd1024;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_BAND_PLAN = 2'd0,
      CSR_REF_COUNT = 2'd1
   } csr_index_type;

   typedef enum logic {
      PLAN_VHF = 1'b0,
      PLAN_UHF = 1'b1
   } band_plan_type;

   // Width of the remainder f mod 1000 and of the exact A value.
   localparam int unsigned RemWidth  = 10;
   localparam int unsigned AExtWidth = 7;

   // Band edges in kHz.
   localparam logic [31:0] VhfTop   = 32'd174000;
   localparam logic [31:0] VhfEdge2 = 32'd166000;
   localparam logic [31:0] VhfEdge1 = 32'd158000;
   localparam logic [31:0] VhfEdge0 = 32'd152000;
   localparam logic [31:0] VhfBot   = 32'd134000;
   localparam logic [31:0] UhfTop   = 32'd470000;
   localparam logic [31:0] UhfEdge2 = 32'd455000;
   localparam logic [31:0] UhfEdge1 = 32'd430000;
   localparam logic [31:0] UhfEdge0 = 32'd418000;
   localparam logic [31:0] UhfBot   = 32'd406000;

   // Per-item control that travels from the front end to the serializer.
   typedef struct packed {
      logic       changed;
      logic [1:0] band;
   } item_ctrl_type;

   // Picks the band select bits, keeping the old ones when no range matches.
   function automatic logic [1:0] pick_band(logic plan, logic [31:0] f, logic [1:0] old);
      logic [1:0] b;
      b = old;
      if (plan == PLAN_VHF) begin
         if (f >= VhfEdge2 && f < VhfTop)   b = 2'd0;
         if (f >= VhfEdge1 && f < VhfEdge2) b = 2'd1;
         if (f >= VhfEdge0 && f < VhfEdge1) b = 2'd2;
         if (f >= VhfBot   && f < VhfEdge0) b = 2'd3;
      end else begin
         if (f >= UhfEdge2 && f < UhfTop)   b = 2'd0;
         if (f >= UhfEdge1 && f < UhfEdge2) b = 2'd1;
         if (f >= UhfEdge0 && f < UhfEdge1) b = 2'd2;
         if (f >= UhfBot   && f < UhfEdge0) b = 2'd3;
      end
      return b;
   endfunction

endpackage

// ===== hw/rtl/pbsl_intf.sv =====
// Channel interfaces for the request, response and configuration ports.
interface pbsl_req_if #(
   parameter int unsigned FreqWidth = pbsl_pkg::FreqWidthDef
) ();
   logic                 valid;
   logic                 ready;
   logic [FreqWidth-1:0] frequency_khz;
   modport source (output valid, output frequency_khz, input ready);
   modport sink (input valid, input frequency_khz, output ready);
endinterface

interface pbsl_rsp_if ();
   logic valid;
   logic ready;
   logic serial_bit;
   logic bit_valid;
   logic latch_after;
   logic select_line;
   logic band_sel_low;
   logic band_sel_high;
   logic last;
   modport source (output valid, output serial_bit, output bit_valid, output latch_after,
                   output select_line, output band_sel_low, output band_sel_high,
                   output last, input ready);
   modport sink (input valid, input serial_bit, input bit_valid, input latch_after,
                 input select_line, input band_sel_low, input band_sel_high,
                 input last, output ready);
endinterface

interface pbsl_csr_if ();
   logic                                valid;
   logic                                ready;
   logic [pbsl_pkg::CsrIndexWidth-1:0] index;
   logic [pbsl_pkg::CsrDataWidth-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/pbsl_front.sv =====
// Front end: accepts frequencies, picks the band, detects changes and computes N and A.
module pbsl_front #(
   parameter int unsigned FreqWidth = pbsl_pkg::FreqWidthDef,
   parameter int unsigned NWidth    = pbsl_pkg::NWidthDef,
   parameter int unsigned AWidth    = pbsl_pkg::AWidthDef
) (
   input  logic                    clock,
   input  logic                    reset,
   pbsl_req_if.sink                req_chan,
   input  logic                    band_plan,
   output logic                    push_valid,
   input  logic                    push_ready,
   output pbsl_pkg::item_ctrl_type push_ctrl,
   output logic [NWidth-1:0]       push_n,
   output logic [AWidth-1:0]       push_a
);

   // f/1000 is (f>>3)/125, done as a multiply by a rounded-up reciprocal.
   localparam int unsigned DivW   = FreqWidth - 3;
   localparam int unsigned NqW    = DivW - 6;
   localparam int unsigned ProdW  = 2 * DivW + 1;
   localparam logic [DivW:0] NMagic =
      (DivW+1)'(((64'd1 << (DivW + 7)) + 64'd124) / 64'd125);
   localparam logic [FreqWidth-1:0] Thousand = FreqWidth'(1000);
   // floor(x/25) for x below 2048 is (x * 2622) >> 16.
   localparam logic [11:0] AMagic = 12'd2622;

   logic                 enable;
   logic                 accept;
   logic [1:0]           band_new;

   logic [FreqWidth-1:0] prev_ff, prev_in;
   logic [1:0]           band_ff, band_in;

   logic                    s1_valid_ff, s2_valid_ff, s3_valid_ff;
   pbsl_pkg::item_ctrl_type s1_ctrl_ff, s2_ctrl_ff, s3_ctrl_ff;
   logic [FreqWidth-1:0]    s1_freq_ff, s2_freq_ff;
   logic [NqW-1:0]          s2_n_ff, s3_n_ff;
   logic [pbsl_pkg::RemWidth-1:0] s3_rem_ff;

   logic [ProdW-1:0]     n_prod;
   logic [FreqWidth-1:0] rem_full;
   logic [22:0]          a_prod;
   logic [pbsl_pkg::AExtWidth-1:0] a_val;
   logic [NqW+NWidth-1:0] n_ext;
   logic [pbsl_pkg::AExtWidth+AWidth-1:0] a_ext;

   assign enable          = !s3_valid_ff || push_ready;
   assign req_chan.ready  = enable;
   assign accept          = req_chan.valid && enable;

   assign band_new = pbsl_pkg::pick_band(band_plan, 32'(req_chan.frequency_khz), band_ff);
   assign band_in  = accept ? band_new : band_ff;
   assign prev_in  = accept ? req_chan.frequency_khz : prev_ff;

   assign n_prod   = {{(DivW+1){1'b0}}, s1_freq_ff[FreqWidth-1:3]} * {{DivW{1'b0}}, NMagic};
   assign rem_full = s2_freq_ff - FreqWidth'(s2_n_ff) * Thousand;
   assign a_prod   = {12'd0, s3_rem_ff, 1'b0} * {11'd0, AMagic};
   assign a_val    = a_prod[22:16];

   assign n_ext = {{NWidth{1'b0}}, s3_n_ff};
   assign a_ext = {{AWidth{1'b0}}, a_val};

   assign push_valid = s3_valid_ff;
   assign push_ctrl  = s3_ctrl_ff;
   assign push_n     = n_ext[NWidth-1:0];
   assign push_a     = a_ext[AWidth-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff     <= '0;
         band_ff     <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         prev_ff <= prev_in;
         band_ff <= band_in;
         if (enable) begin
            s1_valid_ff <= accept;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s1_ctrl_ff.changed <= req_chan.frequency_khz != prev_ff;
         s1_ctrl_ff.band    <= band_new;
         s1_freq_ff         <= req_chan.frequency_khz;
         s2_ctrl_ff         <= s1_ctrl_ff;
         s2_freq_ff         <= s1_freq_ff;
         s2_n_ff            <= n_prod[DivW+7 +: NqW];
         s3_ctrl_ff         <= s2_ctrl_ff;
         s3_n_ff            <= s2_n_ff;
         s3_rem_ff          <= rem_full[pbsl_pkg::RemWidth-1:0];
      end
   end

endmodule

// ===== hw/rtl/pbsl_fifo.sv =====
// Small first-in first-out queue between the front end and the serializer.
module pbsl_fifo #(
   parameter int unsigned DataWidth = 8,
   parameter int unsigned Depth     = pbsl_pkg::QueueDepthDef
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [DataWidth-1:0] push_data,
   output logic                 full,
   input  logic                 pop,
   output logic [DataWidth-1:0] pop_data,
   output logic                 empty
);

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   logic [DataWidth-1:0] mem [Depth];
   logic [PtrW-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]      count_ff;
   logic                 do_push, do_pop;

   assign full     = count_ff == FullCnt;
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== hw/rtl/pbsl_back.sv =====
// Serializer: turns queued items into one response transaction per shifted bit, or one band-only transaction.
module pbsl_back #(
   parameter int unsigned RefWidth = pbsl_pkg::RefWidthDef,
   parameter int unsigned NWidth   = pbsl_pkg::NWidthDef,
   parameter int unsigned AWidth   = pbsl_pkg::AWidthDef
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  item_valid,
   output logic                                  item_pop,
   input  pbsl_pkg::item_ctrl_type               item_ctrl,
   input  logic [NWidth-1:0]                     item_n,
   input  logic [AWidth-1:0]                     item_a,
   input  logic [pbsl_pkg::RefCountWidth-1:0]    ref_count,
   pbsl_rsp_if.source                            rsp_chan
);

   // Load word: reference, control 1, N, A, control 0.
   localparam int unsigned WordW = RefWidth + NWidth + AWidth + 2;
   localparam int unsigned IdxW  = $clog2(WordW);
   localparam logic [IdxW-1:0] LatchIdx = IdxW'(RefWidth);
   localparam logic [IdxW-1:0] LastIdx  = IdxW'(WordW - 1);

   logic [RefWidth+pbsl_pkg::RefCountWidth-1:0] ref_wide;
   logic [WordW-1:0] word;

   logic             active_ff, active_in;
   logic [WordW-1:0] shift_ff, shift_in;
   logic [IdxW-1:0]  idx_ff, idx_in;
   logic [1:0]       band_ff, band_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic bit_ff, bit_in, bvalid_ff, bvalid_in, latch_ff, latch_in;
   logic sel_ff, sel_in, last_ff, last_in;
   logic [1:0] rband_ff, rband_in;

   logic            load_en;
   logic [IdxW-1:0] cur_idx;

   assign ref_wide = {{RefWidth{1'b0}}, ref_count};
   assign word     = {ref_wide[RefWidth-1:0], 1'b1, item_n, item_a, 1'b0};
   assign load_en  = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      active_in    = active_ff;
      shift_in     = shift_ff;
      idx_in       = idx_ff;
      band_in      = band_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      bit_in       = bit_ff;
      bvalid_in    = bvalid_ff;
      latch_in     = latch_ff;
      sel_in       = sel_ff;
      last_in      = last_ff;
      rband_in     = rband_ff;
      item_pop     = 1'b0;
      cur_idx      = idx_ff;
      if (load_en) begin
         if (active_ff) begin
            // Continue shifting the word of the current item.
            rsp_valid_in = 1'b1;
            bit_in       = shift_ff[WordW-1];
            bvalid_in    = 1'b1;
            latch_in     = (cur_idx == LatchIdx) || (cur_idx == LastIdx);
            sel_in       = cur_idx == LastIdx;
            last_in      = cur_idx == LastIdx;
            rband_in     = band_ff;
            shift_in     = shift_ff << 1;
            idx_in       = idx_ff + 1'b1;
            active_in    = cur_idx != LastIdx;
         end else if (item_valid) begin
            item_pop     = 1'b1;
            rsp_valid_in = 1'b1;
            rband_in     = item_ctrl.band;
            band_in      = item_ctrl.band;
            if (item_ctrl.changed) begin
               cur_idx   = '0;
               bit_in    = word[WordW-1];
               bvalid_in = 1'b1;
               latch_in  = cur_idx == LatchIdx;
               sel_in    = 1'b0;
               last_in   = 1'b0;
               shift_in  = word << 1;
               idx_in    = IdxW'(1);
               active_in = 1'b1;
            end else begin
               // Unchanged frequency: a single band-only transaction.
               bit_in    = 1'b0;
               bvalid_in = 1'b0;
               latch_in  = 1'b0;
               sel_in    = 1'b1;
               last_in   = 1'b1;
            end
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff  <= shift_in;
      band_ff   <= band_in;
      bit_ff    <= bit_in;
      bvalid_ff <= bvalid_in;
      latch_ff  <= latch_in;
      sel_ff    <= sel_in;
      last_ff   <= last_in;
      rband_ff  <= rband_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.serial_bit    = bit_ff;
   assign rsp_chan.bit_valid     = bvalid_ff;
   assign rsp_chan.latch_after   = latch_ff;
   assign rsp_chan.select_line   = sel_ff;
   assign rsp_chan.band_sel_low  = rband_ff[0];
   assign rsp_chan.band_sel_high = rband_ff[1];
   assign rsp_chan.last          = last_ff;

endmodule

// ===== hw/rtl/pll_band_select_serial_loader_top.sv =====
// Top level of the PLL band select and serial loader with its configuration registers.
//
//   Channel   Direction  Payload                                   Transaction
//   req_chan  in         frequency_khz                             one frequency
//   rsp_chan  out        serial_bit, bit_valid, latch_after,       one serial bit or
//                        select_line, band_sel_low/high, last      one band-only result
//   csr_chan  in         index, data                               one register write
//
// A changed frequency yields RefWidth + NWidth + AWidth + 2 (33 by default) response
// transactions from the serializer's one-bit-per-cycle shift register, one per cycle
// while rsp_chan.ready is high. An unchanged frequency yields one transaction.
// The front end passes requests through s1, s2, s3 to the queue, accepting until the
// queue fills, and the queue lets the serializer stall on rsp_chan.ready independently.
// Synchronous active-high reset clears all control state; csr_chan is always ready.
module pll_band_select_serial_loader_top #(
   parameter int unsigned FreqWidth  = pbsl_pkg::FreqWidthDef,
   parameter int unsigned RefWidth   = pbsl_pkg::RefWidthDef,
   parameter int unsigned NWidth     = pbsl_pkg::NWidthDef,
   parameter int unsigned AWidth     = pbsl_pkg::AWidthDef,
   parameter int unsigned QueueDepth = pbsl_pkg::QueueDepthDef
) (
   input  logic       clock,
   input  logic       reset,
   pbsl_req_if.sink   req_chan,
   pbsl_rsp_if.source rsp_chan,
   pbsl_csr_if.sink   csr_chan
);

   localparam int unsigned EntryW = 3 + NWidth + AWidth;

   logic                                band_plan_ff;
   logic [pbsl_pkg::RefCountWidth-1:0] ref_count_ff;

   logic                    push_valid, push_ready;
   pbsl_pkg::item_ctrl_type push_ctrl;
   logic [NWidth-1:0]       push_n;
   logic [AWidth-1:0]       push_a;

   logic                    q_full, q_empty, q_pop;
   logic [EntryW-1:0]       q_wdata, q_rdata;
   pbsl_pkg::item_ctrl_type item_ctrl;
   logic [NWidth-1:0]       item_n;
   logic [AWidth-1:0]       item_a;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         band_plan_ff <= pbsl_pkg::PLAN_VHF;
         ref_count_ff <= pbsl_pkg::RefCountReset;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            pbsl_pkg::CSR_BAND_PLAN: band_plan_ff <= csr_chan.data[0];
            pbsl_pkg::CSR_REF_COUNT: ref_count_ff <= csr_chan.data[pbsl_pkg::RefCountWidth-1:0];
            default: ;
         endcase
      end
   end

   pbsl_front #(
      .FreqWidth (FreqWidth),
      .NWidth    (NWidth),
      .AWidth    (AWidth)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .band_plan  (band_plan_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_ctrl  (push_ctrl),
      .push_n     (push_n),
      .push_a     (push_a)
   );

   assign push_ready = !q_full;
   assign q_wdata    = {push_ctrl, push_n, push_a};
   assign item_ctrl  = q_rdata[EntryW-1 -: 3];
   assign item_n     = q_rdata[AWidth +: NWidth];
   assign item_a     = q_rdata[AWidth-1:0];

   pbsl_fifo #(
      .DataWidth (EntryW),
      .Depth     (QueueDepth)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .empty     (q_empty)
   );

   pbsl_back #(
      .RefWidth (RefWidth),
      .NWidth   (NWidth),
      .AWidth   (AWidth)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (!q_empty),
      .item_pop   (q_pop),
      .item_ctrl  (item_ctrl),
      .item_n     (item_n),
      .item_a     (item_a),
      .ref_count  (ref_count_ff),
      .rsp_chan   (rsp_chan)
   );

endmodule
